// File: rtl/wps_pkg.sv
// shared types, constants and tables of the waypoint pursuit steering block
`default_nettype none

package wps_pkg;

    localparam int MAX_WAYPOINTS = 256;
    localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
    localparam int WP_CW         = WP_AW + 1;

    localparam int IN_W      = 34;
    localparam int POS_W     = 32;
    localparam int SPEED_W   = 16;
    localparam int RATE_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CMD_W     = 3;

    localparam int CORDIC_N = 24;
    localparam int CW       = 48;
    localparam int ZW       = 34;
    localparam int DIST_W   = 34;
    localparam int PROD_W   = 47;
    localparam int NUM_W    = 58;
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(31);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_N - 1);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(NUM_W - 1);

    localparam logic [CW-1:0]     CORDIC_K_Q30 = CW'(652032874);
    localparam logic [RATE_W-1:0] RATE_LIMIT   = 32'd2000000000;
    localparam logic [10:0]       RATE_GAIN    = 11'd2000;

    // command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_FIX    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_EAST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_NORTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE     = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_TOGGLE,
        OP_CLEAR,
        OP_FIX_POS,
        OP_FIX_DIFF,
        OP_TICK_DIFF,
        OP_DIST_INIT,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQRT_STEP,
        OP_VEC_INIT,
        OP_NORM,
        OP_VEC_PREP,
        OP_CORDIC_V,
        OP_HEAD_SET,
        OP_ERR_SET,
        OP_SINE_INIT,
        OP_CORDIC_R,
        OP_MUL1,
        OP_MUL2,
        OP_DIV_STEP,
        OP_RATE,
        OP_TICK_END,
        OP_OUT_OFF,
        OP_OUT_END,
        OP_OUT_VEL
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             enabled;
        logic             tick_avail;
        logic             last_sqrt;
        logic             last_cordic;
        logic             last_div;
        logic             dist_zero;
        logic             dist_gt_min;
        logic             vec_zero;
        logic             norm_small;
        logic             out_free;
    } dp_stat_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/wps_ctrl.sv
// sequencer for the waypoint pursuit steering datapath
`default_nettype none

module wps_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              s_tvalid,
    output logic             in_ready,
    input  wps_pkg::dp_stat_t stat,
    output wps_pkg::op_t     op
);
    import wps_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_DECODE    = 23'h000002,
        S_FIX_POS   = 23'h000004,
        S_FIX_DIFF  = 23'h000008,
        S_TICK_DIFF = 23'h000010,
        S_DIST_INIT = 23'h000020,
        S_SQ_X      = 23'h000040,
        S_SQ_Y      = 23'h000080,
        S_SQRT      = 23'h000100,
        S_DIST_CHK  = 23'h000200,
        S_VEC_INIT  = 23'h000400,
        S_NORM      = 23'h000800,
        S_VEC_PREP  = 23'h001000,
        S_CORDIC_V  = 23'h002000,
        S_BEAR_DONE = 23'h004000,
        S_SINE_INIT = 23'h008000,
        S_CORDIC_R  = 23'h010000,
        S_MUL1      = 23'h020000,
        S_MUL2      = 23'h040000,
        S_DIV       = 23'h080000,
        S_RATE      = 23'h100000,
        S_TICK_END  = 23'h200000,
        S_OUT       = 23'h400000
    } state_t;

    state_t state_reg, state_next;
    logic   is_tick_reg, is_tick_next;
    op_t    out_op_reg, out_op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            is_tick_reg <= 1'b0;
            out_op_reg  <= OP_OUT_OFF;
        end
        else
        begin
            state_reg   <= state_next;
            is_tick_reg <= is_tick_next;
            out_op_reg  <= out_op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        is_tick_next = is_tick_reg;
        out_op_next  = out_op_reg;
        op           = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next   = S_IDLE;
                is_tick_next = (stat.cmd == CMD_TICK);
                case (stat.cmd)
                    CMD_FIX:
                    begin
                        if (stat.enabled)
                            state_next = S_FIX_POS;
                    end
                    CMD_TICK:
                    begin
                        if (!stat.enabled)
                        begin
                            out_op_next = OP_OUT_OFF;
                            state_next  = S_OUT;
                        end
                        else if (!stat.tick_avail)
                        begin
                            out_op_next = OP_OUT_END;
                            state_next  = S_OUT;
                        end
                        else
                            state_next = S_TICK_DIFF;
                    end
                    CMD_LOAD:   op = OP_LOAD;
                    CMD_TOGGLE: op = OP_TOGGLE;
                    CMD_CLEAR:  op = OP_CLEAR;
                    default:    op = OP_NONE;
                endcase
            end
            S_FIX_POS:
            begin
                op         = OP_FIX_POS;
                state_next = S_FIX_DIFF;
            end
            S_FIX_DIFF:
            begin
                op         = OP_FIX_DIFF;
                state_next = S_DIST_INIT;
            end
            S_TICK_DIFF:
            begin
                op         = OP_TICK_DIFF;
                state_next = S_DIST_INIT;
            end
            S_DIST_INIT:
            begin
                op         = OP_DIST_INIT;
                state_next = S_SQ_X;
            end
            S_SQ_X:
            begin
                op         = OP_SQ_X;
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                op         = OP_SQ_Y;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op = OP_SQRT_STEP;
                if (stat.last_sqrt)
                    state_next = S_DIST_CHK;
            end
            S_DIST_CHK:
            begin
                if (is_tick_reg)
                    state_next = stat.dist_zero ? S_TICK_END : S_VEC_INIT;
                else
                    state_next = stat.dist_gt_min ? S_VEC_INIT : S_IDLE;
            end
            S_VEC_INIT:
            begin
                op         = OP_VEC_INIT;
                state_next = stat.vec_zero ? S_BEAR_DONE : S_NORM;
            end
            S_NORM:
            begin
                if (stat.norm_small)
                    op = OP_NORM;
                else
                    state_next = S_VEC_PREP;
            end
            S_VEC_PREP:
            begin
                op         = OP_VEC_PREP;
                state_next = S_CORDIC_V;
            end
            S_CORDIC_V:
            begin
                op = OP_CORDIC_V;
                if (stat.last_cordic)
                    state_next = S_BEAR_DONE;
            end
            S_BEAR_DONE:
            begin
                if (is_tick_reg)
                begin
                    op         = OP_ERR_SET;
                    state_next = S_SINE_INIT;
                end
                else
                begin
                    op         = OP_HEAD_SET;
                    state_next = S_IDLE;
                end
            end
            S_SINE_INIT:
            begin
                op         = OP_SINE_INIT;
                state_next = S_CORDIC_R;
            end
            S_CORDIC_R:
            begin
                op = OP_CORDIC_R;
                if (stat.last_cordic)
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                op         = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                op         = OP_MUL2;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op = OP_DIV_STEP;
                if (stat.last_div)
                    state_next = S_RATE;
            end
            S_RATE:
            begin
                op         = OP_RATE;
                state_next = S_TICK_END;
            end
            S_TICK_END:
            begin
                op          = OP_TICK_END;
                out_op_next = OP_OUT_VEL;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    op         = out_op_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a finished result always goes out and frees the sequencer
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("result stage did not return to idle");

endmodule

`default_nettype wire

// File: rtl/wps_dp.sv
// datapath: waypoint table, pose state, square root, cordic and divider
`default_nettype none

module wps_dp (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wps_pkg::op_t                 op,
    output wps_pkg::dp_stat_t            stat,
    input  wire [wps_pkg::CMD_W-1:0]     in_cmd,
    input  wire [wps_pkg::IN_W-1:0]      in_east,
    input  wire [wps_pkg::IN_W-1:0]      in_north,
    input  wire                          cfg_valid,
    input  wire [wps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [wps_pkg::IN_W-1:0]      cfg_data,
    input  wire                          out_ready,
    output logic                         out_valid,
    output logic                         out_kind,
    output logic [wps_pkg::SPEED_W-1:0]  out_speed,
    output logic [wps_pkg::RATE_W-1:0]   out_rate
);
    import wps_pkg::*;

    localparam logic signed [34:0] REL_MAX = 35'sd2147483647;
    localparam logic signed [34:0] REL_MIN = -35'sd2147483648;
    localparam logic [CW-1:0]      NORM_LIM = CW'(64'd1 << 40);

    function automatic logic signed [POS_W-1:0] rel32(input logic [IN_W-1:0] v,
                                                     input logic [IN_W-1:0] org);
        logic signed [34:0] d;
        d = $signed({1'b0, v}) - $signed({1'b0, org});
        if (d > REL_MAX)
            return 32'sh7FFFFFFF;
        else if (d < REL_MIN)
            return 32'sh80000000;
        return d[POS_W-1:0];
    endfunction

    function automatic logic [CW-1:0] abs48(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // shift that truncates toward zero
    function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                    input logic [4:0] i);
        logic [CW-1:0] m;
        m = abs48(v) >> i;
        return v[CW-1] ? -$signed(m) : $signed(m);
    endfunction

    // configuration
    logic [IN_W-1:0]    origin_e_reg, origin_n_reg;
    logic [SPEED_W-1:0] max_speed_reg, lookahead_reg, min_move_reg;

    // pose and path state
    logic [WP_CW-1:0]        count_reg, target_reg;
    logic                    enabled_reg, have_last_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, last_x_reg, last_y_reg;
    logic [15:0]             heading_reg;
    logic                    out_valid_reg;

    // waypoint table
    logic signed [POS_W-1:0] mem_x [MAX_WAYPOINTS];
    logic signed [POS_W-1:0] mem_y [MAX_WAYPOINTS];
    logic signed [POS_W-1:0] wx_reg, wy_reg;

    // working registers
    logic [CMD_W-1:0]        cmd_reg;
    logic [IN_W-1:0]         east_reg, north_reg;
    logic signed [32:0]      dx_reg, dy_reg;
    logic [30:0]             ax_reg, ay_reg;
    logic [1:0]              sh_reg;
    logic [61:0]             sq_reg;
    logic [63:0]             n_reg, r_reg, bit_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg;
    logic signed [ZW-1:0]    cz_reg;
    logic                    vzero_reg, sneg_reg, sign_reg;
    logic [15:0]             err_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [NUM_W-1:0]        q_reg;
    logic [DIST_W-1:0]       rem_reg;
    logic [RATE_W-1:0]       rate_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    kind_reg;
    logic [SPEED_W-1:0]      speed_reg;
    logic [RATE_W-1:0]       orate_reg;

    logic signed [POS_W-1:0] rel_x, rel_y;
    logic                    table_full;
    logic [32:0]             adx, ady;
    logic [31:0]             ax_w, ay_w;
    logic [1:0]              sh_w;
    logic [61:0]             sq_y;
    logic [63:0]             sq_t, r_new, n_new;
    logic                    sq_ge;
    logic [DIST_W-1:0]       dist_new;
    logic [4:0]              ci;
    logic signed [CW-1:0]    xs, ys;
    logic [ZW-1:0]           at;
    logic                    rot_neg;
    logic [31:0]             bsum;
    logic [15:0]             bear;
    logic [31:0]             sin_a;
    logic [CW-1:0]           ymag;
    logic [DIST_W:0]         rs;
    logic                    dge;
    logic [RATE_W-1:0]       mag;

    assign rel_x      = rel32(east_reg, origin_e_reg);
    assign rel_y      = rel32(north_reg, origin_n_reg);
    assign table_full = (count_reg >= WP_CW'(MAX_WAYPOINTS));
    assign sq_y       = ay_reg * ay_reg;

    // magnitude prescale for the square root
    always_comb
    begin
        adx  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ady  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        ax_w = adx[31:0];
        ay_w = ady[31:0];
        sh_w = 2'd0;
        for (int k = 0; k < 2; k++)
        begin
            if (ax_w[31] || ay_w[31])
            begin
                ax_w = ax_w >> 1;
                ay_w = ay_w >> 1;
                sh_w = sh_w + 2'd1;
            end
        end
    end

    // one square root digit per cycle
    always_comb
    begin
        sq_t     = r_reg + bit_reg;
        sq_ge    = (n_reg >= sq_t);
        r_new    = sq_ge ? (r_reg >> 1) + bit_reg : (r_reg >> 1);
        n_new    = sq_ge ? n_reg - sq_t : n_reg;
        dist_new = {2'b00, r_new[31:0]} << sh_reg;
    end

    // shared cordic stage, vectoring or rotation
    always_comb
    begin
        ci      = cnt_reg[4:0];
        xs      = shr_tz(cx_reg, ci);
        ys      = shr_tz(cy_reg, ci);
        at      = {2'b00, atan_lut(ci)};
        rot_neg = (op == OP_CORDIC_V) ? (cy_reg > 0) : cz_reg[ZW-1];
        bsum    = cz_reg[31:0] + 32'h0000_8000;
        bear    = vzero_reg ? 16'd0 : bsum[31:16];
        sin_a   = {err_reg, 16'h0000};
        ymag    = abs48(cy_reg);
    end

    // one quotient bit per cycle
    always_comb
    begin
        rs  = {rem_reg, q_reg[NUM_W-1]};
        dge = (rs >= {1'b0, dist_reg});
        mag = {4'b0000, q_reg[NUM_W-1:30]};
        if (mag > RATE_LIMIT)
            mag = RATE_LIMIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_e_reg  <= '0;
            origin_n_reg  <= '0;
            max_speed_reg <= '0;
            lookahead_reg <= 16'd500;
            min_move_reg  <= 16'd500;
            count_reg     <= '0;
            target_reg    <= '0;
            enabled_reg   <= 1'b0;
            have_last_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ORIGIN_EAST:  origin_e_reg  <= cfg_data;
                    CFG_ORIGIN_NORTH: origin_n_reg  <= cfg_data;
                    CFG_MAX_SPEED:    max_speed_reg <= cfg_data[SPEED_W-1:0];
                    CFG_LOOKAHEAD:    lookahead_reg <= cfg_data[SPEED_W-1:0];
                    CFG_MIN_MOVE:     min_move_reg  <= cfg_data[SPEED_W-1:0];
                    default:          ;
                endcase
            end
            if (op == OP_OUT_OFF || op == OP_OUT_END || op == OP_OUT_VEL)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (op)
                OP_LOAD:
                begin
                    if (!table_full)
                        count_reg <= count_reg + WP_CW'(1);
                end
                OP_TOGGLE:
                    enabled_reg <= !enabled_reg;
                OP_CLEAR:
                begin
                    count_reg  <= '0;
                    target_reg <= '0;
                end
                OP_FIX_POS:
                begin
                    pos_x_reg <= rel_x;
                    pos_y_reg <= rel_y;
                    if (!have_last_reg)
                    begin
                        last_x_reg    <= rel_x;
                        last_y_reg    <= rel_y;
                        have_last_reg <= 1'b1;
                    end
                end
                OP_HEAD_SET:
                begin
                    heading_reg <= bear;
                    last_x_reg  <= pos_x_reg;
                    last_y_reg  <= pos_y_reg;
                end
                OP_TICK_END:
                begin
                    if (dist_reg < {18'd0, lookahead_reg})
                        target_reg <= target_reg + WP_CW'(1);
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD && !table_full)
        begin
            mem_x[count_reg[WP_AW-1:0]] <= rel_x;
            mem_y[count_reg[WP_AW-1:0]] <= rel_y;
        end
        wx_reg <= mem_x[target_reg[WP_AW-1:0]];
        wy_reg <= mem_y[target_reg[WP_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_CAPTURE:
            begin
                cmd_reg   <= in_cmd;
                east_reg  <= in_east;
                north_reg <= in_north;
            end
            OP_FIX_DIFF:
            begin
                dx_reg <= {pos_x_reg[POS_W-1], pos_x_reg} - {last_x_reg[POS_W-1], last_x_reg};
                dy_reg <= {pos_y_reg[POS_W-1], pos_y_reg} - {last_y_reg[POS_W-1], last_y_reg};
            end
            OP_TICK_DIFF:
            begin
                dx_reg   <= {wx_reg[POS_W-1], wx_reg} - {pos_x_reg[POS_W-1], pos_x_reg};
                dy_reg   <= {wy_reg[POS_W-1], wy_reg} - {pos_y_reg[POS_W-1], pos_y_reg};
                rate_reg <= '0;
            end
            OP_DIST_INIT:
            begin
                ax_reg <= ax_w[30:0];
                ay_reg <= ay_w[30:0];
                sh_reg <= sh_w;
            end
            OP_SQ_X:
                sq_reg <= ax_reg * ax_reg;
            OP_SQ_Y:
            begin
                n_reg   <= {2'b00, sq_reg} + {2'b00, sq_y};
                r_reg   <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                n_reg   <= n_new;
                r_reg   <= r_new;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == SQRT_LAST)
                    dist_reg <= dist_new;
            end
            OP_VEC_INIT:
            begin
                cx_reg    <= CW'(dx_reg);
                cy_reg    <= CW'(dy_reg);
                cz_reg    <= '0;
                vzero_reg <= (dx_reg == '0) && (dy_reg == '0);
            end
            OP_NORM:
            begin
                cx_reg <= cx_reg <<< 1;
                cy_reg <= cy_reg <<< 1;
            end
            OP_VEC_PREP:
            begin
                if (cx_reg[CW-1])
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                    cz_reg <= ZW'(33'h0_8000_0000);
                end
                cnt_reg <= '0;
            end
            OP_CORDIC_V, OP_CORDIC_R:
            begin
                if (rot_neg)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + $signed(at);
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - $signed(at);
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_ERR_SET:
                err_reg <= bear - heading_reg;
            OP_SINE_INIT:
            begin
                // fold the left half plane onto the right one
                sneg_reg <= err_reg[15] ^ err_reg[14];
                cz_reg   <= (err_reg[15] ^ err_reg[14])
                          ? ZW'($signed(sin_a ^ 32'h8000_0000))
                          : ZW'($signed(sin_a));
                cx_reg   <= CORDIC_K_Q30;
                cy_reg   <= '0;
                cnt_reg  <= '0;
            end
            OP_MUL1:
            begin
                prod_reg <= ymag[30:0] * max_speed_reg;
                sign_reg <= sneg_reg ? (cy_reg > 0) : cy_reg[CW-1];
            end
            OP_MUL2:
            begin
                q_reg   <= prod_reg * RATE_GAIN;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= dge ? DIST_W'(rs - {1'b0, dist_reg}) : rs[DIST_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], dge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            OP_RATE:
                rate_reg <= sign_reg ? RATE_W'(-mag) : mag;
            OP_OUT_OFF:
            begin
                kind_reg  <= 1'b0;
                speed_reg <= '0;
                orate_reg <= '0;
            end
            OP_OUT_END:
            begin
                kind_reg  <= 1'b1;
                speed_reg <= '0;
                orate_reg <= '0;
            end
            OP_OUT_VEL:
            begin
                kind_reg  <= 1'b0;
                speed_reg <= max_speed_reg;
                orate_reg <= rate_reg;
            end
            default:
                ;
        endcase
    end

    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.enabled     = enabled_reg;
        stat.tick_avail  = (target_reg < count_reg);
        stat.last_sqrt   = (cnt_reg == SQRT_LAST);
        stat.last_cordic = (cnt_reg == CORDIC_LAST);
        stat.last_div    = (cnt_reg == DIV_LAST);
        stat.dist_zero   = (dist_reg == '0);
        stat.dist_gt_min = (dist_reg > {18'd0, min_move_reg});
        stat.vec_zero    = (dx_reg == '0) && (dy_reg == '0);
        stat.norm_small  = (abs48(cx_reg) < NORM_LIM) && (abs48(cy_reg) < NORM_LIM);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_speed = speed_reg;
    assign out_rate  = orate_reg;

    a_target_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        target_reg <= count_reg)
        else $error("target index ran past the loaded path");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= WP_CW'(MAX_WAYPOINTS))
        else $error("waypoint count beyond table depth");

    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(orate_reg) <= $signed(RATE_LIMIT)
                        && $signed(orate_reg) >= -$signed(RATE_LIMIT)))
        else $error("turn rate outside saturation limits");

endmodule

`default_nettype wire

// File: rtl/waypoint_pursuit_steering.sv
// Pure-pursuit waypoint follower. Slave stream: tuser = cmd (0 fix,
// 1 tick, 2 load, 3 toggle enable, 4 clear), tdata = east, north in mm.
// Master stream: one result per control tick, tuser = kind (0 velocity,
// 1 path finished), tdata = linear_speed, angular_rate. The cfg channel
// writes origin_east, origin_north, max_speed, lookahead_mm, min_move_mm
// at indexes 0..4 and is always ready; write it only while idle.
// One request is worked on at a time; s_tready is high only when idle.
// A fix or an enabled tick with a target runs a 32-step square root; a
// fix that updates the heading and a tick at nonzero distance then run
// normalizing steps plus 24 vectoring steps on a shared CORDIC, and the
// tick goes on with 24 rotation steps and a 58-step restoring divider.
// The result sits in an output register; a stalled receiver blocks only
// the next tick at its final step, other requests keep flowing.
// Reset clears the path, position, heading, enable and the result
// valid flag and loads the configuration defaults; it needs no sweep.
`default_nettype none

module waypoint_pursuit_steering (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [71:0]  s_tdata,   // east_mm[33:0], north_mm[67:34], zero pad
    input  wire [2:0]   s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // linear_speed[15:0], angular_rate[47:16]
    output logic [0:0]  m_tuser,   // kind[0]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [2:0]   cfg_index,
    input  wire [33:0]  cfg_data
);
    import wps_pkg::*;

    op_t                op;
    dp_stat_t           stat;
    logic               in_ready;
    logic               out_kind;
    logic [SPEED_W-1:0] out_speed;
    logic [RATE_W-1:0]  out_rate;

    wps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    wps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .stat      (stat),
        .in_cmd    (s_tuser),
        .in_east   (s_tdata[33:0]),
        .in_north  (s_tdata[67:34]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_speed (out_speed),
        .out_rate  (out_rate)
    );

    assign s_tready   = in_ready;
    assign cfg_ready  = 1'b1;
    assign m_tdata    = {out_rate, out_speed};
    assign m_tuser[0] = out_kind;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for the waypoint pursuit steering block
`timescale 1ns / 1ps

module tb_top;
    import wps_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IN_W-1:0]  east;
        logic [IN_W-1:0]  north;
    } nav_req_t;

    typedef struct {
        logic                kind;
        logic [SPEED_W-1:0]  speed;
        logic [RATE_W-1:0]   rate;
    } steer_cmd_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [71:0] s_tdata;
    logic [2:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [47:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [33:0] cfg_data;

    waypoint_pursuit_steering u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state
    logic signed [31:0] wp_x [MAX_WAYPOINTS];
    logic signed [31:0] wp_y [MAX_WAYPOINTS];
    int unsigned wp_count, wp_target;
    bit nav_on, have_prev;
    logic signed [31:0] cur_x, cur_y, prev_x, prev_y;
    logic [15:0] head;
    logic [33:0] org_e, org_n;
    logic [15:0] speed_cfg, reach_cfg, move_cfg;

    nav_req_t   pending_reqs[$];
    steer_cmd_t expected_cmds[$];

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned ticks_sent;
    longint unsigned cycles;
    bit hold_sender;

    function automatic logic signed [31:0] offset_pos(logic [33:0] v, logic [33:0] org);
        longint d;
        d = longint'(v) - longint'(org);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d[31:0];
    endfunction

    function automatic longint trunc_shift(longint v, int i);
        if (v >= 0) return v >>> i;
        return -((-v) >>> i);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned range_mm(longint dx, longint dy);
        longint unsigned ax, ay;
        int s;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        s = 0;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31))
        begin
            ax = ax >> 1;
            ay = ay >> 1;
            s++;
        end
        return int_sqrt(ax * ax + ay * ay) << s;
    endfunction

    function automatic logic [31:0] arctan_step(int i);
        logic [31:0] t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return t[i];
    endfunction

    function automatic logic [15:0] heading_to(longint x, longint y);
        logic [31:0] z;
        longint xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        while ((x < 0 ? -x : x) < (64'sd1 << 40) && (y < 0 ? -y : y) < (64'sd1 << 40))
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 24; i++)
        begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += arctan_step(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arctan_step(i);
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic longint sin_q30(logic [15:0] ang);
        logic [31:0] a;
        bit neg;
        longint x, y, z, xs, ys;
        a = {ang, 16'd0};
        neg = 0;
        x = 652032874;
        y = 0;
        if (a >= 32'h4000_0000 && a < 32'hC000_0000)
        begin
            a = a - 32'h8000_0000;
            neg = 1;
        end
        z = longint'(signed'(a));
        for (int i = 0; i < 24; i++)
        begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= longint'(arctan_step(i));
            end
            else
            begin
                x += ys; y -= xs; z += longint'(arctan_step(i));
            end
        end
        return neg ? -y : y;
    endfunction

    task automatic predict_steering(nav_req_t r);
        longint dx, dy, s, rate;
        longint unsigned d, mag;
        logic [15:0] err;
        steer_cmd_t c;
        case (r.cmd)
            CMD_FIX:
                if (nav_on)
                begin
                    cur_x = offset_pos(r.east, org_e);
                    cur_y = offset_pos(r.north, org_n);
                    if (!have_prev)
                    begin
                        prev_x = cur_x; prev_y = cur_y; have_prev = 1;
                    end
                    dx = longint'(cur_x) - longint'(prev_x);
                    dy = longint'(cur_y) - longint'(prev_y);
                    if (range_mm(dx, dy) > move_cfg)
                    begin
                        head = heading_to(dx, dy);
                        prev_x = cur_x; prev_y = cur_y;
                    end
                end
            CMD_TICK:
            begin
                c.kind = 0; c.speed = 0; c.rate = 0;
                if (nav_on && wp_target >= wp_count)
                    c.kind = 1;
                else if (nav_on)
                begin
                    dx = longint'(wp_x[wp_target]) - longint'(cur_x);
                    dy = longint'(wp_y[wp_target]) - longint'(cur_y);
                    d = range_mm(dx, dy);
                    rate = 0;
                    if (d != 0)
                    begin
                        err = heading_to(dx, dy) - head;
                        s = sin_q30(err);
                        mag = 64'd2000 * longint'(s < 0 ? -s : s) * speed_cfg;
                        mag = (mag / d) >> 30;
                        if (mag > 2000000000) mag = 2000000000;
                        rate = s < 0 ? -longint'(mag) : longint'(mag);
                    end
                    if (d < reach_cfg) wp_target++;
                    c.speed = speed_cfg;
                    c.rate = rate[31:0];
                end
                expected_cmds = {expected_cmds, c};
            end
            CMD_LOAD:
                if (wp_count < MAX_WAYPOINTS)
                begin
                    wp_x[wp_count] = offset_pos(r.east, org_e);
                    wp_y[wp_count] = offset_pos(r.north, org_n);
                    wp_count++;
                end
            CMD_TOGGLE: nav_on = !nav_on;
            CMD_CLEAR:
            begin
                wp_count = 0; wp_target = 0;
            end
            default: ;
        endcase
    endtask

    // driver: one request at a time from the pending queue
    int unsigned send_gap;
    nav_req_t cur_req;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_steering(cur_req);
            if (s_tvalid && !s_tready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !hold_sender)
            begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_req.cmd;
                s_tdata <= {4'd0, cur_req.north, cur_req.east};
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        steer_cmd_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d data=%h", m_tuser, m_tdata);
                end
                else
                begin
                    e = expected_cmds.pop_front();
                    if (m_tuser[0] !== e.kind || m_tdata[15:0] !== e.speed
                        || m_tdata[47:16] !== e.rate)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp kind=%0d speed=%0d rate=%0d,",
                                " got kind=%0d speed=%0d rate=%0d"},
                                e.kind, e.speed, $signed(e.rate), m_tuser[0],
                                m_tdata[15:0], $signed(m_tdata[47:16]));
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready && $urandom_range(0, 2) != 0)
                    stall_left = $urandom_range(0, 13);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout waiting on the block");
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [33:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 34'd0;
            1: return 34'h3_FFFF_FFFF;
            2: return 34'({$urandom(), $urandom()} % 35'd10000000001);
            default: return 34'd5_000_000_000 + $urandom_range(0, 40000) - 20000;
        endcase
    endfunction

    task automatic queue_req(logic [2:0] c, logic [33:0] e, logic [33:0] n);
        nav_req_t r;
        r.cmd = c; r.east = e; r.north = n;
        pending_reqs = {pending_reqs, r};
        if (c == CMD_TICK) ticks_sent++;
    endtask

    // write a register and mirror it in the predictor; callers drain first
    task automatic write_reg(logic [2:0] idx, logic [33:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_EAST:  org_e = v;
            CFG_ORIGIN_NORTH: org_n = v;
            CFG_MAX_SPEED:    speed_cfg = v[15:0];
            CFG_LOOKAHEAD:    reach_cfg = v[15:0];
            default:          move_cfg = v[15:0];
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_cmds.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic run_route(int legs);
        longint bx, by, sx, sy;
        bx = 64'd5_000_000_000 + $urandom_range(0, 100000);
        by = 64'd5_000_000_000 + $urandom_range(0, 100000);
        queue_req(CMD_CLEAR, rand_coord(), rand_coord());
        for (int i = 0; i < legs; i++)
            queue_req(CMD_LOAD, 34'(bx + $urandom_range(0, 20000)),
                34'(by + $urandom_range(0, 20000)));
        sx = bx;
        sy = by;
        for (int i = 0; i < legs * 3; i++)
        begin
            if ($urandom_range(0, 1))
            begin
                sx += $urandom_range(0, 3000) - 1000;
                sy += $urandom_range(0, 3000) - 1000;
                queue_req(CMD_FIX, 34'(sx), 34'(sy));
            end
            else
                queue_req(CMD_TICK, rand_coord(), rand_coord());
            if ($urandom_range(0, 40) == 0)
                queue_req(CMD_TOGGLE, rand_coord(), rand_coord());
            if ($urandom_range(0, 40) == 0)
                queue_req(3'($urandom_range(5, 7)), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        int n;
        mismatches = 0; results_seen = 0; ticks_sent = 0; cycles = 0;
        hold_sender = 0;
        wp_count = 0; wp_target = 0; nav_on = 0; have_prev = 0;
        cur_x = 0; cur_y = 0; prev_x = 0; prev_y = 0; head = 0;
        org_e = 0; org_n = 0; speed_cfg = 0; reach_cfg = 500; move_cfg = 500;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, disabled tick, finished tick, extremes
        queue_req(CMD_TICK, 0, 0);
        queue_req(CMD_FIX, 34'd1000, 34'd1000);
        queue_req(CMD_TOGGLE, 0, 0);
        queue_req(CMD_TICK, 0, 0);
        queue_req(CMD_FIX, 34'h3_FFFF_FFFF, 34'h3_FFFF_FFFF);
        queue_req(CMD_FIX, 34'd0, 34'd0);
        queue_req(CMD_LOAD, 34'd0, 34'd0);
        queue_req(CMD_LOAD, 34'h3_FFFF_FFFF, 34'd0);
        queue_req(CMD_TICK, 0, 0);
        queue_req(CMD_TICK, 0, 0);
        queue_req(CMD_TICK, 0, 0);
        queue_req(3'd5, 0, 0);
        queue_req(3'd7, 34'h3_FFFF_FFFF, 34'h3_FFFF_FFFF);
        queue_req(CMD_CLEAR, 0, 0);
        queue_req(CMD_TICK, 0, 0);
        drain();

        write_reg(CFG_MAX_SPEED, 34'hFFFF);
        write_reg(CFG_LOOKAHEAD, 34'd0);
        write_reg(CFG_MIN_MOVE, 34'd0);
        write_reg(CFG_ORIGIN_EAST, 34'd10000000000);
        write_reg(CFG_ORIGIN_NORTH, 34'd0);
        queue_req(CMD_FIX, 34'd0, 34'd0);
        queue_req(CMD_FIX, 34'd10000000000, 34'd10000000000);
        queue_req(CMD_LOAD, 34'd10000000000, 34'd10000000000);
        queue_req(CMD_TICK, 0, 0);
        // full table: loads past the end are dropped
        for (int i = 0; i < MAX_WAYPOINTS + 2; i++)
            queue_req(CMD_LOAD, $urandom_range(0, 9999), $urandom_range(0, 9999));
        queue_req(CMD_TICK, 0, 0);
        queue_req(CMD_CLEAR, 0, 0);
        drain();

        // random routes over several register settings
        n = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_ORIGIN_EAST, 34'd5_000_000_000 - $urandom_range(0, 50000));
            write_reg(CFG_ORIGIN_NORTH, phase == 5 ? 34'd0 : 34'd5_000_000_000);
            write_reg(CFG_MAX_SPEED, phase == 0 ? 34'd0 : $urandom_range(0, 65535));
            write_reg(CFG_LOOKAHEAD, phase == 1 ? 34'hFFFF : $urandom_range(0, 5000));
            write_reg(CFG_MIN_MOVE, phase == 2 ? 34'hFFFF : $urandom_range(0, 1500));
            if (!nav_on) queue_req(CMD_TOGGLE, 0, 0);
            while (n < (phase + 1) * 110)
            begin
                run_route($urandom_range(1, 8));
                n = n + 30;
                if (phase == 3)
                begin
                    // let the block catch up before more requests
                    while (pending_reqs.size() > 0 || s_tvalid) @(posedge clk);
                    hold_sender = 1;
                    while (expected_cmds.size() > 0) @(posedge clk);
                    hold_sender = 0;
                end
            end
            drain();
        end

        $display("covered %0d ticks with %0d results checked over six register settings",
            ticks_sent, results_seen);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
